FILE: hw/rtl/lepe_pkg.sv
// ----------------------------------------------------------------------------
// lepe_pkg
// Shared constants, command/status structs and small tables for the
// log-price path evolver.
// ----------------------------------------------------------------------------
package lepe_pkg;

   // ln(2) in Q.40, and its multiples used by the range reduction
   localparam logic [46:0] LN2_Q40      = 47'd762123384786;
   // 35*ln2 lifts any in-range sum to a non-negative dividend
   localparam logic [46:0] K_OFFSET     = 47'd26674318467510;
   localparam logic [6:0]  K_BIAS_SHIFT = 7'd65;   // 30 + 35
   // floor(2^56 / LN2_Q40): quotient estimate from the dividend's bits 45:24
   localparam logic [16:0] LN2_RECIP    = 17'd94548;
   // exp() input limits, magnitudes in Q.40
   localparam logic [46:0] EXP_HIGH     = 47'd23 << 40;
   localparam logic [46:0] EXP_LOW_MAG  = 47'd24 << 40;
   localparam logic [30:0] ONE_Q30      = 31'd1 << 30;

   localparam int unsigned SQRT_STEPS   = 30;
   localparam int unsigned TAYLOR_TERMS = 12;
   localparam int unsigned DIV_CYCLES   = 3;

   // ln2 reduction phases, counted down by the controller
   localparam logic [1:0] DIV_EST  = 2'd2;
   localparam logic [1:0] DIV_BACK = 2'd1;
   localparam logic [1:0] DIV_FIX  = 2'd0;

   // datapath commands issued by the controller
   typedef struct packed {
      logic       load;
      logic       sqrt_step;
      logic       diff;
      logic       acc;
      logic       check;
      logic       div_step;
      logic [1:0] div_phase;
      logic       tay_mul;
      logic       tay_recip;
      logic       tay_fix;
      logic [3:0] tay_n;
      logic       price;
      logic       fin;
      logic       out_load;
   } lepe_cmd_type;

   // datapath status back to the controller
   typedef struct packed {
      logic last;
      logic special;
      logic out_busy;
   } lepe_sts_type;

   // floor(2^32 / n) for the Taylor term divide
   function automatic logic [32:0] recip_q32(input logic [3:0] n);
      logic [32:0] r;
      case (n)
         4'd1:    r = 33'd4294967296;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd1431655765;
         4'd4:    r = 33'd1073741824;
         4'd5:    r = 33'd858993459;
         4'd6:    r = 33'd715827882;
         4'd7:    r = 33'd613566756;
         4'd8:    r = 33'd536870912;
         4'd9:    r = 33'd477218588;
         4'd10:   r = 33'd429496729;
         4'd11:   r = 33'd390451572;
         4'd12:   r = 33'd357913941;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/lepe_ctrl.sv
// ----------------------------------------------------------------------------
// lepe_ctrl
// Sequencer: steps the square root, accumulate, range reduction, Taylor
// series and final scaling, and issues datapath commands.
// ----------------------------------------------------------------------------
module lepe_ctrl
   import lepe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  lepe_sts_type sts,
   output lepe_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQRT, S_DIFF, S_ACC, S_CHECK, S_DIV,
      S_TMUL, S_TRCP, S_TFIX, S_PRICE, S_FIN, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  n_ff, n_in;

   assign req_tready = (state_ff == S_IDLE);

   // command decode
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && req_tvalid;
      cmd.sqrt_step = (state_ff == S_SQRT);
      cmd.diff      = (state_ff == S_DIFF);
      cmd.acc       = (state_ff == S_ACC);
      cmd.check     = (state_ff == S_CHECK);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.div_phase = cnt_ff[1:0];
      cmd.tay_mul   = (state_ff == S_TMUL);
      cmd.tay_recip = (state_ff == S_TRCP);
      cmd.tay_fix   = (state_ff == S_TFIX);
      cmd.tay_n     = n_ff;
      cmd.price     = (state_ff == S_PRICE);
      cmd.fin       = (state_ff == S_FIN);
      cmd.out_load  = (state_ff == S_OUT) && !sts.out_busy;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SQRT;
               cnt_in   = '0;
            end
         end
         S_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) state_in = S_DIFF;
         end
         S_DIFF:  state_in = S_ACC;
         S_ACC:   state_in = sts.last ? S_CHECK : S_IDLE;
         S_CHECK: begin
            cnt_in   = 5'(DIV_CYCLES - 1);
            state_in = sts.special ? S_OUT : S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_TMUL;
               n_in     = 4'd1;
            end
         end
         S_TMUL: state_in = S_TRCP;
         S_TRCP: state_in = S_TFIX;
         S_TFIX: begin
            if (n_ff == 4'(TAYLOR_TERMS)) begin
               state_in = S_PRICE;
            end else begin
               n_in     = n_ff + 4'd1;
               state_in = S_TMUL;
            end
         end
         S_PRICE: state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (!sts.out_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
      end
   end

   // result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_busy) else $error("result overwritten");

   // an accepted item always starts the root iteration
   a_accept_sqrt: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SQRT && cnt_ff == 5'd0))
      else $error("accept did not start root");

   // root counter stays in range
   a_sqrt_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (cnt_ff < 5'(SQRT_STEPS))) else $error("root count");

   // Taylor term index stays 1..12
   a_tay_n: assert property (@(posedge clock) disable iff (reset)
      (cmd.tay_mul || cmd.tay_fix) |-> (n_ff >= 4'd1 && n_ff <= 4'(TAYLOR_TERMS)))
      else $error("taylor index");

   // datapath commands are exclusive
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sqrt_step, cmd.diff, cmd.acc, cmd.check, cmd.div_step,
                cmd.tay_mul, cmd.tay_recip, cmd.tay_fix, cmd.price, cmd.fin,
                cmd.out_load})) else $error("command overlap");

endmodule

FILE: hw/rtl/lepe_dp.sv
// ----------------------------------------------------------------------------
// lepe_dp
// Datapath: drift multiply, bit-serial square root, diffusion multiply,
// saturating accumulator, exp by range reduction and Taylor series, result.
// ----------------------------------------------------------------------------
module lepe_dp
   import lepe_pkg::*;
#(
   parameter int unsigned LOG_ACC_WIDTH = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  lepe_cmd_type       cmd,
   output lepe_sts_type       sts,
   input  logic [31:0]        spot_price,
   input  logic [31:0]        step_size,
   input  logic [31:0]        in_variance,
   input  logic signed [31:0] in_increment,
   input  logic               in_last,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_price,
   output logic               rsp_sat
);

   localparam int unsigned W  = LOG_ACC_WIDTH;
   localparam int unsigned SW = ((W > 47) ? W : 47) + 1;
   localparam logic signed [SW-1:0] ACC_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

   logic [31:0]        v_ff;
   logic signed [31:0] w_ff;
   logic               last_ff;
   logic [59:0]        n_ff;
   logic [31:0]        rem_ff;
   logic [29:0]        root_ff;
   logic [42:0]        drift_ff;
   logic signed [46:0] diff_ff;
   logic signed [W-1:0] acc_ff;
   logic [46:0]        y_ff;
   logic [6:0]         q_ff;
   logic [30:0]        t_ff, a_ff, q0_ff;
   logic [31:0]        e_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        price_ff;
   logic               sat_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_price_ff;
   logic               rsp_sat_ff;

   // square root digit
   logic [33:0] rem_sh, trial;
   logic        take;
   assign rem_sh = {rem_ff, n_ff[59:58]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   // multiplies
   logic [63:0]        drift_prod;
   logic signed [62:0] diff_prod;
   logic [60:0]        tay_prod;
   logic [63:0]        rcp_prod;
   logic [34:0]        fix_prod;
   logic [34:0]        fix_rem;
   assign drift_prod = 64'(v_ff) * 64'(step_size);
   assign diff_prod  = $signed({33'd0, root_ff}) * $signed({{31{w_ff[31]}}, w_ff});
   assign tay_prod   = 61'(t_ff) * 61'(y_ff[39:10]);
   assign rcp_prod   = 64'(a_ff) * 64'(recip_q32(cmd.tay_n));
   assign fix_prod   = 35'(q0_ff) * 35'(cmd.tay_n);
   assign fix_rem    = 35'(a_ff) - fix_prod;

   // saturating accumulate
   logic signed [SW-1:0] sum_w, sum_c, x_w;
   assign sum_w = $signed({{(SW-W){acc_ff[W-1]}}, acc_ff})
                + $signed({{(SW-47){diff_ff[46]}}, diff_ff})
                - $signed({{(SW-43){1'b0}}, drift_ff});
   always_comb begin
      if (sum_w > ACC_HI)      sum_c = ACC_HI;
      else if (sum_w < ACC_LO) sum_c = ACC_LO;
      else                     sum_c = sum_w;
   end

   // exp input limits
   logic signed [SW-1:0] x_lo;
   logic is_zero, is_high;
   assign x_w     = $signed({{(SW-W){acc_ff[W-1]}}, acc_ff});
   assign x_lo    = x_w + $signed({{(SW-47){1'b0}}, EXP_LOW_MAG});
   assign is_zero = (spot_price == 32'd0) || (x_lo <= 0);
   assign is_high = (x_w >= $signed({{(SW-47){1'b0}}, EXP_HIGH}));

   // divide by ln2: the estimate is never high and at most one low
   logic [38:0] k_est_prod;
   logic [46:0] k_back;
   assign k_est_prod = 39'(y_ff[45:24]) * 39'(LN2_RECIP);
   assign k_back     = 47'(q_ff) * LN2_Q40;

   // final scaling by 2^k
   logic signed [7:0] sh;
   logic [1:0]  ls;
   logic [31:0] lim;
   logic [63:0] ps;
   logic [31:0] fin_price;
   logic        fin_sat;
   assign sh  = $signed({1'b0, K_BIAS_SHIFT}) - $signed({1'b0, q_ff});
   assign ls  = 2'(-sh);
   assign lim = 32'hFFFF_FFFF >> ls;
   assign ps  = prod_ff >> sh[5:0];
   always_comb begin
      fin_price = '0;
      fin_sat   = 1'b0;
      if (sh >= 8'sd64) begin
         fin_price = '0;
      end else if (sh <= 8'sd0) begin
         if (prod_ff > 64'(lim)) begin
            fin_price = 32'hFFFF_FFFF;
            fin_sat   = 1'b1;
         end else begin
            fin_price = 32'(prod_ff << ls);
         end
      end else if (ps[63:32] != 32'd0) begin
         fin_price = 32'hFFFF_FFFF;
         fin_sat   = 1'b1;
      end else begin
         fin_price = ps[31:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff    <= in_variance;
         w_ff    <= in_increment;
         last_ff <= in_last;
         n_ff    <= {in_variance, 28'd0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         n_ff     <= {n_ff[57:0], 2'b00};
         drift_ff <= drift_prod[63:21];
         if (take) begin
            rem_ff  <= 32'(rem_sh - trial);
            root_ff <= {root_ff[28:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[31:0];
            root_ff <= {root_ff[28:0], 1'b0};
         end
      end
      if (cmd.diff) diff_ff <= 47'(diff_prod >>> 16);
      if (cmd.check) begin
         y_ff     <= 47'(x_w + $signed({{(SW-47){1'b0}}, K_OFFSET}));
         q_ff     <= '0;
         t_ff     <= ONE_Q30;
         e_ff     <= 32'(ONE_Q30);
         price_ff <= is_zero ? 32'd0 : 32'hFFFF_FFFF;
         sat_ff   <= !is_zero && is_high;
      end
      // ln2 reduction: reciprocal estimate, back multiply, one correction
      if (cmd.div_step) begin
         case (cmd.div_phase)
            DIV_EST:  q_ff <= k_est_prod[38:32];
            DIV_BACK: y_ff <= y_ff - k_back;
            DIV_FIX: begin
               if (y_ff >= LN2_Q40) begin
                  y_ff <= y_ff - LN2_Q40;
                  q_ff <= q_ff + 7'd1;
               end
            end
            default: ;
         endcase
      end
      if (cmd.tay_mul)   a_ff  <= tay_prod[60:30];
      if (cmd.tay_recip) q0_ff <= rcp_prod[62:32];
      if (cmd.tay_fix) begin
         if (fix_rem >= 35'(cmd.tay_n)) begin
            t_ff <= q0_ff + 31'd1;
            e_ff <= e_ff + 32'(q0_ff) + 32'd1;
         end else begin
            t_ff <= q0_ff;
            e_ff <= e_ff + 32'(q0_ff);
         end
      end
      if (cmd.price) prod_ff <= 64'(spot_price) * 64'(e_ff);
      if (cmd.fin) begin
         price_ff <= fin_price;
         sat_ff   <= fin_sat;
      end
      if (cmd.out_load) begin
         rsp_price_ff <= price_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   // control registers: accumulator and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.acc)           acc_ff <= W'(sum_c);
         else if (cmd.out_load) acc_ff <= '0;
         if (cmd.out_load)      rsp_valid_ff <= 1'b1;
         else if (rsp_tready)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_price    = rsp_price_ff;
   assign rsp_sat      = rsp_sat_ff;
   assign sts.last     = last_ff;
   assign sts.special  = is_zero || is_high;
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

endmodule

FILE: hw/rtl/log_euler_path_evolver.sv
// ----------------------------------------------------------------------------
// log_euler_path_evolver
// Fixed-point Euler step of a log price; emits spot*exp(sum) at path end.
// ----------------------------------------------------------------------------
// One item at a time. A step that does not end a path runs from one transfer
// to the next through the accept cycle, the bit-serial square root (one
// root bit per cycle), one diffusion multiply and one accumulate. A last
// step adds the exp: a range check, a reduction by ln2 (reciprocal estimate,
// back multiply, correction), 12 Taylor terms, each a multiply, a reciprocal
// multiply and a correction, the price multiply and the 2^k scale, and a load
// of the result register; a sum outside the exp range skips straight from
// the range check to the result load. A result still waiting holds the load
// cycle until the receiver takes it. The result sits in its own register,
// and the next item is taken while it waits. Registers: spot_price at 0x0,
// step_size at 0x4.
// ----------------------------------------------------------------------------
module log_euler_path_evolver
   import lepe_pkg::*;
#(
   parameter int unsigned LOG_ACC_WIDTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // variance[31:0], brownian_increment[63:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // terminal_price[31:0]
   output logic        rsp_tuser,    // saturated[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]  spot_ff, step_ff;
   lepe_cmd_type cmd;
   lepe_sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spot_ff <= 32'd65536;
         step_ff <= 32'd42949673;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2]) step_ff <= csr_pwdata;
         else              spot_ff <= csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? step_ff : spot_ff;

   lepe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lepe_dp #(
      .LOG_ACC_WIDTH (LOG_ACC_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .spot_price   (spot_ff),
      .step_size    (step_ff),
      .in_variance  (req_tdata[31:0]),
      .in_increment ($signed(req_tdata[63:32])),
      .in_last      (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_price    (rsp_tdata),
      .rsp_sat      (rsp_tuser)
   );

endmodule

FILE: tb/lepe_price_checker.sv
// ----------------------------------------------------------------------------
// lepe_price_checker
// Watches the step, result and register ports of the path evolver, predicts
// every terminal price from the steps that transfer and compares each result.
// ----------------------------------------------------------------------------
module lepe_price_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,    // variance[31:0], brownian_increment[63:32]
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // terminal_price[31:0]
   input  logic        rsp_tuser,    // saturated[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_prices
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_SPOT = 3'd0;
   localparam logic [2:0] ADDR_STEP = 3'd4;
   localparam longint LN2_Q40_C  = 64'sd762123384786;
   localparam longint SUM_MAX    = (64'sd1 <<< 47) - 1;
   localparam longint SUM_MIN    = -(64'sd1 <<< 47);
   localparam longint EXP_TOP    = 64'sd23 <<< 40;
   localparam longint EXP_BOTTOM = -(64'sd24 <<< 40);

   typedef struct packed {
      logic [31:0] price;
      logic        sat;
   } price_type;

   price_type   price_q[$];
   logic [31:0] spot_reg;
   logic [31:0] dt_reg;
   longint      log_sum;

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bits;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n   = n - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // spot * exp(x), floor rounded, clamped to 32 bits
   function automatic price_type exp_price(input longint x, input logic [31:0] spot);
      price_type       o;
      longint          k, r;
      longint unsigned r30, t, e, prod;
      int              sh;
      o = '0;
      if (spot == 0 || x <= EXP_BOTTOM) return o;
      if (x >= EXP_TOP) return '{32'hFFFF_FFFF, 1'b1};
      k = x / LN2_Q40_C;
      if (x < 0 && k * LN2_Q40_C != x) k = k - 1;
      r   = x - k * LN2_Q40_C;
      r30 = longint'(r) >> 10;
      e   = 64'd1 << 30;
      t   = 64'd1 << 30;
      for (int n = 1; n <= 12; n++) begin
         t = ((t * r30) >> 30) / longint'(n);
         e = e + t;
      end
      prod = {32'd0, spot} * e;
      sh   = 30 - int'(k);
      if (sh >= 64) return o;
      if (sh <= 0) begin
         if (prod > (64'hFFFF_FFFF >> (-sh))) return '{32'hFFFF_FFFF, 1'b1};
         o.price = 32'(prod << (-sh));
         return o;
      end
      prod = prod >> sh;
      if (prod > 64'hFFFF_FFFF) return '{32'hFFFF_FFFF, 1'b1};
      o.price = prod[31:0];
      return o;
   endfunction

   assign pending_prices = price_q.size();

   always @(posedge clock) begin
      longint unsigned var_u, drift, root;
      longint          incr, diff, wsig;
      price_type       got, want;
      int              errs;
      errs = 0;
      if (reset) begin
         spot_reg   <= 32'd65536;
         dt_reg     <= 32'd42949673;
         log_sum    = 0;
         price_q.delete();
         fail_count <= 0;
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_SPOT) spot_reg <= csr_pwdata;
            else if (csr_paddr == ADDR_STEP) dt_reg <= csr_pwdata;
         end
         // step transfer: advance the log sum, maybe close the path
         if (req_tvalid && req_tready) begin
            var_u = {32'd0, req_tdata[31:0]};
            wsig  = longint'($signed(req_tdata[63:32]));
            drift = (var_u * {32'd0, dt_reg}) >> 21;
            root  = int_sqrt(var_u << 28);
            diff  = (longint'(root) * wsig) >>> 16;
            incr  = diff - longint'(drift);
            log_sum = log_sum + incr;
            if (log_sum > SUM_MAX) log_sum = SUM_MAX;
            if (log_sum < SUM_MIN) log_sum = SUM_MIN;
            if (req_tlast) begin
               price_q.push_back(exp_price(log_sum, spot_reg));
               log_sum = 0;
            end
         end
         // result transfer
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser};
            if (price_q.size() == 0) begin
               $error("unexpected result: terminal_price %h saturated %b",
                      got.price, got.sat);
               errs++;
            end else begin
               want = price_q.pop_front();
               if (got.price !== want.price) begin
                  $error("terminal_price: expected %h actual %h", want.price, got.price);
                  errs++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated: expected %b actual %b", want.sat, got.sat);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

FILE: tb/log_euler_path_evolver_tb.sv
// ----------------------------------------------------------------------------
// log_euler_path_evolver_tb
// Drives directed and random price paths through the evolver under several
// spot/dt settings, with bursty input and a stalling receiver; the checker
// predicts and compares every terminal price.
// ----------------------------------------------------------------------------
module log_euler_path_evolver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_SPOT = 3'd0;
   localparam logic [2:0] ADDR_STEP = 3'd4;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_WAIT = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_prices;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   log_euler_path_evolver u_top (.*);

   lepe_price_checker u_check (.*);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall pattern, one long hold-off, periodic always-ready windows
   always @(negedge clock) begin
      if (cycle_count > 3000 && cycle_count <= 3600)
         rsp_tready <= 1'b0;
      else if (cycle_count[11:9] == 3'd5)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // one step transfer; bursts of random length separated by random gaps
   task automatic send_step(input logic [31:0] v, input logic [31:0] w, input logic last);
      if (burst_left == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 40)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
      end else begin
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, v};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left = burst_left - 1;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_prices != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] scaled_rand();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   task automatic random_paths(input int count);
      int   sent, len;
      logic [31:0] w;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: a lone step with arbitrary fields
            send_step($urandom, $urandom, $urandom_range(0, 1));
            sent++;
         end else begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
               w = scaled_rand();
               if ($urandom_range(0, 1)) w = -w;
               send_step(($urandom_range(0, 7) == 0) ? $urandom : scaled_rand(), w,
                         i == len - 1);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes and the special cases
      send_step(32'd0, 32'd0, 1'b1);
      send_step(32'hFFFF_FFFF, 32'h0, 1'b1);
      send_step(32'h1000_0000, 32'h1000_0000, 1'b1);
      send_step(32'd1, 32'hFFFF_FFFF, 1'b1);
      // positive accumulator clamp, then large sum saturation
      repeat (6) send_step(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_step(32'd0, 32'd0, 1'b1);
      // negative clamp, then small sum
      repeat (6) send_step(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
      send_step(32'd0, 32'd0, 1'b1);
      send_step(32'h4000_0000, 32'h8000_0000, 1'b1);
      settle();

      // extreme and random settings
      csr_write(ADDR_SPOT, 32'd1);
      csr_write(ADDR_STEP, 32'd0);
      random_paths(175);
      settle();
      csr_write(ADDR_SPOT, 32'hFFFF_FFFF);
      csr_write(ADDR_STEP, 32'hFFFF_FFFF);
      send_step(32'h1000_0000, 32'h1000_0000, 1'b1);
      random_paths(175);
      settle();
      csr_write(ADDR_SPOT, 32'd0);
      csr_write(ADDR_STEP, $urandom);
      random_paths(150);
      settle();
      repeat (3) begin
         csr_write(ADDR_SPOT, $urandom);
         csr_write(ADDR_STEP, $urandom);
         random_paths(175);
         settle();
      end

      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/lepe_pkg.sv
hw/rtl/lepe_ctrl.sv
hw/rtl/lepe_dp.sv
hw/rtl/log_euler_path_evolver.sv
tb/lepe_price_checker.sv
tb/log_euler_path_evolver_tb.sv
